// File: hdl/hav_pkg.sv
// hav_pkg: shared constants, types and tables for the great-circle distance block
// no dependencies
package hav_pkg;

  localparam int ITERATIONS_DEF      = 24;
  localparam int ANGLE_FRAC_BITS_DEF = 20;

  localparam int LNG_W  = 29;
  localparam int LAT_W  = 28;
  localparam int DIST_W = 22;

  // angles in degrees * 2^21
  localparam int DEG_W = 32;
  localparam logic signed [DEG_W-1:0] DEG90  = 32'sd188743680;
  localparam logic signed [DEG_W-1:0] DEG180 = 32'sd377487360;
  localparam logic signed [DEG_W-1:0] DEG360 = 32'sd754974720;

  localparam logic [26:0] RAD_PER_DEG_Q32 = 27'd74961320;
  localparam logic [29:0] GAIN_INV_Q30    = 30'd652032874;
  localparam logic [21:0] RADIUS_RESET    = 22'd1013504;

  typedef enum logic [1:0] {
    REG_OWN_LNG = 2'd0,
    REG_OWN_LAT = 2'd1,
    REG_RADIUS  = 2'd2
  } cfg_reg_t;

  function automatic logic [29:0] atan_q30(input int i);
    logic [29:0] t;
    case (i)
      0:  t = 30'h3243F6A8 & 30'h3FFFFFFF;
      1:  t = 30'h1DAC6705;
      2:  t = 30'h0FADBAFC;
      3:  t = 30'h07F56EA6;
      4:  t = 30'h03FEAB76;
      5:  t = 30'h01FFD55B;
      6:  t = 30'h00FFFAAA;
      7:  t = 30'h007FFF55;
      8:  t = 30'h003FFFEA;
      9:  t = 30'h001FFFFD;
      10: t = 30'h000FFFFF;
      11: t = 30'h0007FFFF;
      12: t = 30'h0003FFFF;
      13: t = 30'h0001FFFF;
      14: t = 30'h0000FFFF;
      15: t = 30'h00007FFF;
      16: t = 30'h00003FFF;
      17: t = 30'h00001FFF;
      18: t = 30'h00000FFF;
      19: t = 30'h000007FF;
      20: t = 30'h000003FF;
      21: t = 30'h000001FF;
      22: t = 30'h000000FF;
      23: t = 30'h0000007F;
      24: t = 30'h0000003F;
      25: t = 30'h0000001F;
      26: t = 30'h0000000F;
      27: t = 30'h00000007;
      28: t = 30'h00000003;
      29: t = 30'h00000001;
      default: t = 30'h0;
    endcase
    return t;
  endfunction

endpackage

// File: hdl/haversine_distance.sv
// haversine_distance: top level, great-circle distance to a configured point
// depends on hav_pkg, hav_rot_cell, hav_vec_cell, hav_sqrt_cell
//
// Usage: a query word (longitude, latitude) enters on the in_ stream; one
// result word (distance, valid flag) leaves on the out_ stream for each.
// The reference point and earth radius are set through the cfg_ write port
// while no query is in flight; index above 2 is ignored.
// Datapath is a chain of registered cells: four parallel CORDIC rotation
// chains of ITERATIONS cells, square-root chains of 32 cells, and a
// vectoring chain of ITERATIONS cells, plus a few multiply stages.
// One word can be taken every cycle while the output is not stalled. The
// whole pipeline advances only when the output register is free or being
// read, so a stall at out_tready holds every stage and in_tready drops.
// Reset (synchronous, active low) clears the stage valid bits and restores
// the register defaults; no sweep is needed.
module haversine_distance #(
  parameter int ITERATIONS      = hav_pkg::ITERATIONS_DEF,
  parameter int ANGLE_FRAC_BITS = hav_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // point_longitude[28:0], point_latitude[56:29]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // distance[21:0], valid_res[22]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [28:0] cfg_data
);
  import hav_pkg::*;

  localparam int F   = ANGLE_FRAC_BITS;
  localparam int W   = F + 4;
  localparam int VW  = 64;
  localparam int SQN = 32;
  localparam int LAT = 2 * ITERATIONS + SQN + 9;

  // -------- configuration --------
  logic signed [LNG_W-1:0] own_lng_r;
  logic signed [LAT_W-1:0] own_lat_r;
  logic [DIST_W-1:0]       radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_lng_r <= '0;
      own_lat_r <= '0;
      radius_r  <= RADIUS_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_OWN_LNG: own_lng_r <= cfg_data[LNG_W-1:0];
        REG_OWN_LAT: own_lat_r <= cfg_data[LAT_W-1:0];
        REG_RADIUS:  radius_r  <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // -------- pipeline control --------
  logic adv;
  logic [LAT-1:0] vld_r;
  logic out_v_r;

  assign adv        = !out_v_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = out_v_r;

  logic accept;
  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      vld_r   <= {vld_r[LAT-2:0], accept};
      out_v_r <= vld_r[LAT-1];
    end
  end

  // one enable shared by every stage, cells included
  logic ce;
  assign ce = adv;

  // -------- stage 0: angle prep --------
  logic signed [LNG_W-1:0] p_lng;
  logic signed [LAT_W-1:0] p_lat;
  assign p_lng = in_tdata[LNG_W-1:0];
  assign p_lat = in_tdata[LNG_W+LAT_W-1:LNG_W];

  logic signed [DEG_W-1:0] ang_r [4];
  logic zero_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      ang_r[0] <= DEG_W'(own_lat_r) <<< 1;
      ang_r[1] <= DEG_W'(p_lat) <<< 1;
      ang_r[2] <= DEG_W'(own_lat_r) - DEG_W'(p_lat);
      ang_r[3] <= DEG_W'(own_lng_r) - DEG_W'(p_lng);
      zero_r   <= (own_lng_r == 0) || (own_lat_r == 0) || (p_lng == 0) || (p_lat == 0);
    end
  end

  // stage 1: wrap and mirror into [-90, 90]
  function automatic logic signed [DEG_W:0] wrap(input logic signed [DEG_W:0] v);
    logic signed [DEG_W:0] t;
    t = v;
    if (t > DEG180) t = t - DEG360;
    if (t > DEG180) t = t - DEG360;
    if (t <= -DEG180) t = t + DEG360;
    if (t <= -DEG180) t = t + DEG360;
    return t;
  endfunction

  logic signed [DEG_W-1:0] fold_r [4];
  logic neg_r [4];
  logic zero1_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 4; k++) begin
        logic signed [DEG_W:0] t;
        t = wrap({ang_r[k][DEG_W-1], ang_r[k]});
        if (t > DEG90) begin
          fold_r[k] <= DEG_W'(DEG180 - t);
          neg_r[k]  <= 1'b1;
        end else if (t < -DEG90) begin
          fold_r[k] <= DEG_W'(-DEG180 - t);
          neg_r[k]  <= 1'b1;
        end else begin
          fold_r[k] <= DEG_W'(t);
          neg_r[k]  <= 1'b0;
        end
      end
      zero1_r <= zero_r;
    end
  end

  // stage 2: degrees to radians
  logic signed [W-1:0] z0_r [4];
  logic neg2_r [4];
  logic zero2_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 4; k++) begin
        logic signed [63:0] prod;
        prod = 64'(fold_r[k]) * $signed({1'b0, RAD_PER_DEG_Q32});
        z0_r[k]   <= W'(prod >>> (53 - F));
        neg2_r[k] <= neg_r[k];
      end
      zero2_r <= zero1_r;
    end
  end

  // -------- rotation chains --------
  localparam logic signed [W-1:0] X0 = W'($signed({1'b0, GAIN_INV_Q30 >> (30 - F)}));

  logic signed [W-1:0] rx [4][ITERATIONS+1];
  logic signed [W-1:0] ry [4][ITERATIONS+1];
  logic signed [W-1:0] rz [4][ITERATIONS+1];
  logic [ITERATIONS-1:0] rneg_r [4];
  logic [ITERATIONS-1:0] rzero_r;

  for (genvar k = 0; k < 4; k++) begin : g_rot
    assign rx[k][0] = X0;
    assign ry[k][0] = '0;
    assign rz[k][0] = z0_r[k];
    for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
      hav_rot_cell #(.W(W), .STEP(i), .FRAC(F)) u_cell (
        .clk(clk), .en(ce), .x_i(rx[k][i]), .y_i(ry[k][i]), .z_i(rz[k][i]),
        .x_o(rx[k][i+1]), .y_o(ry[k][i+1]), .z_o(rz[k][i+1])
      );
    end
    always_ff @(posedge clk) begin
      if (ce) rneg_r[k] <= {rneg_r[k][ITERATIONS-2:0], neg2_r[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) rzero_r <= {rzero_r[ITERATIONS-2:0], zero2_r};
  end

  // -------- haversine term a --------
  logic signed [W-1:0] c1, c2, sl, sg;
  assign c1 = rneg_r[0][ITERATIONS-1] ? -rx[0][ITERATIONS] : rx[0][ITERATIONS];
  assign c2 = rneg_r[1][ITERATIONS-1] ? -rx[1][ITERATIONS] : rx[1][ITERATIONS];
  assign sl = ry[2][ITERATIONS];
  assign sg = ry[3][ITERATIONS];

  logic signed [W-1:0] m_sl_r, m_cc_r, m_sg_r;
  logic signed [W-1:0] m2_sl_r, m2_cs_r;
  logic signed [W+1:0] a_r;
  logic [F:0] ac_r;
  logic [3:0] az_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      m_sl_r  <= W'(((2*W)'(sl) * (2*W)'(sl)) >>> F);
      m_cc_r  <= W'(((2*W)'(c1) * (2*W)'(c2)) >>> F);
      m_sg_r  <= W'(((2*W)'(sg) * (2*W)'(sg)) >>> F);
      m2_sl_r <= m_sl_r;
      m2_cs_r <= W'(((2*W)'(m_cc_r) * (2*W)'(m_sg_r)) >>> F);
      a_r     <= (W+2)'(m2_sl_r) + (W+2)'(m2_cs_r);
      if (a_r < 0) ac_r <= '0;
      else if (a_r > (W+2)'(1 << F)) ac_r <= (F+1)'(1 << F);
      else ac_r <= (F+1)'(a_r);
      az_r <= {az_r[2:0], rzero_r[ITERATIONS-1]};
    end
  end

  // -------- square-root chains --------
  logic [VW-1:0] sv [2][SQN+1];
  logic [VW-1:0] sr [2][SQN+1];
  logic [SQN-1:0] szero_r;

  assign sv[0][0] = VW'(ac_r) << F;
  assign sv[1][0] = VW'((F+1)'(1 << F) - ac_r) << F;
  assign sr[0][0] = '0;
  assign sr[1][0] = '0;

  for (genvar k = 0; k < 2; k++) begin : g_sq
    for (genvar i = 0; i < SQN; i++) begin : g_cell
      hav_sqrt_cell #(.VW(VW), .STEP(i)) u_cell (
        .clk(clk), .en(ce), .v_i(sv[k][i]), .r_i(sr[k][i]),
        .v_o(sv[k][i+1]), .r_o(sr[k][i+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (ce) szero_r <= {szero_r[SQN-2:0], az_r[3]};
  end

  // -------- vectoring chain --------
  logic signed [W-1:0] vx [ITERATIONS+1];
  logic signed [W-1:0] vy [ITERATIONS+1];
  logic signed [W-1:0] vz [ITERATIONS+1];
  logic [ITERATIONS-1:0] vzero_r;

  assign vx[0] = W'(sr[1][SQN]);
  assign vy[0] = W'(sr[0][SQN]);
  assign vz[0] = '0;

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_vec
    hav_vec_cell #(.W(W), .STEP(i), .FRAC(F)) u_cell (
      .clk(clk), .en(ce), .x_i(vx[i]), .y_i(vy[i]), .z_i(vz[i]),
      .x_o(vx[i+1]), .y_o(vy[i+1]), .z_o(vz[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (ce) vzero_r <= {vzero_r[ITERATIONS-2:0], szero_r[SQN-1]};
  end

  // -------- scale by radius --------
  localparam logic [DIST_W-1:0] DIST_MAXV = '1;

  logic [W-1:0] zc_r;
  logic [DIST_W+W:0] d_r;
  logic [1:0] dz_r;
  logic [DIST_W-1:0] dist_r;
  logic res_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      zc_r  <= (vz[ITERATIONS] < 0) ? '0 : W'(vz[ITERATIONS]);
      d_r   <= ((DIST_W+W+1)'(radius_r) * (DIST_W+W+1)'(zc_r)) << 1;
      dz_r  <= {dz_r[0], vzero_r[ITERATIONS-1]};
      if (dz_r[1]) begin
        dist_r <= '0;
        res_r  <= 1'b0;
      end else begin
        dist_r <= ((d_r >> F) > (DIST_W+W+1)'(DIST_MAXV)) ? DIST_W'(DIST_MAXV)
                                                         : DIST_W'(d_r >> F);
        res_r  <= 1'b1;
      end
    end
  end

  assign out_tdata = {1'b0, res_r, dist_r};

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while pipeline stalled");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[22] |-> out_tdata[21:0] == 0)
    else $error("invalid result carries a distance");
`endif
endmodule

// File: hdl/hav_rot_cell.sv
// hav_rot_cell: one CORDIC rotation step (sine/cosine), registered
// depends on hav_pkg
module hav_rot_cell #(
  parameter int W     = 24,
  parameter int STEP  = 0,
  parameter int FRAC  = 20
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] x_i,
  input  logic signed [W-1:0] y_i,
  input  logic signed [W-1:0] z_i,
  output logic signed [W-1:0] x_o,
  output logic signed [W-1:0] y_o,
  output logic signed [W-1:0] z_o
);
  import hav_pkg::*;

  localparam logic [29:0] TAB = atan_q30(STEP) >> (30 - FRAC);
  localparam logic signed [W-1:0] ANG = W'($signed({1'b0, TAB}));

  logic signed [W-1:0] dx, dy;
  logic signed [W-1:0] x_r, y_r, z_r;

  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;

  always_ff @(posedge clk) begin
    if (en) begin
      if (z_i >= 0) begin
        x_r <= x_i - dx;
        y_r <= y_i + dy;
        z_r <= z_i - ANG;
      end else begin
        x_r <= x_i + dx;
        y_r <= y_i - dy;
        z_r <= z_i + ANG;
      end
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;
endmodule

// File: hdl/hav_vec_cell.sv
// hav_vec_cell: one CORDIC vectoring step (arctangent), registered
// depends on hav_pkg
module hav_vec_cell #(
  parameter int W     = 24,
  parameter int STEP  = 0,
  parameter int FRAC  = 20
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] x_i,
  input  logic signed [W-1:0] y_i,
  input  logic signed [W-1:0] z_i,
  output logic signed [W-1:0] x_o,
  output logic signed [W-1:0] y_o,
  output logic signed [W-1:0] z_o
);
  import hav_pkg::*;

  localparam logic [29:0] TAB = atan_q30(STEP) >> (30 - FRAC);
  localparam logic signed [W-1:0] ANG = W'($signed({1'b0, TAB}));

  logic signed [W-1:0] dx, dy;
  logic signed [W-1:0] x_r, y_r, z_r;

  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;

  always_ff @(posedge clk) begin
    if (en) begin
      if (y_i >= 0) begin
        x_r <= x_i + dx;
        y_r <= y_i - dy;
        z_r <= z_i + ANG;
      end else begin
        x_r <= x_i - dx;
        y_r <= y_i + dy;
        z_r <= z_i - ANG;
      end
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;
endmodule

// File: hdl/hav_sqrt_cell.sv
// hav_sqrt_cell: one step of a restoring bit-serial integer square root
// no package dependencies
module hav_sqrt_cell #(
  parameter int VW   = 64,
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [VW-1:0] v_i,
  input  logic [VW-1:0] r_i,
  output logic [VW-1:0] v_o,
  output logic [VW-1:0] r_o
);
  localparam logic [VW-1:0] BIT = VW'(1) << (VW - 2 - 2 * STEP);

  logic [VW-1:0] trial;
  logic [VW-1:0] v_r, r_r;

  assign trial = r_i + BIT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (v_i >= trial) begin
        v_r <= v_i - trial;
        r_r <= (r_i >> 1) + BIT;
      end else begin
        v_r <= v_i;
        r_r <= r_i >> 1;
      end
    end
  end

  assign v_o = v_r;
  assign r_o = r_r;
endmodule

// File: tb/tb_haversine_distance.sv
// tb_haversine_distance: self-checking bench for the great-circle distance block
// depends on hav_pkg and haversine_distance; a bit-exact fixed-point model
// predicts each distance word, the checker compares it in arrival order
module tb_haversine_distance;
  timeunit 1ns;
  timeprecision 1ps;
  import hav_pkg::*;

  localparam int FB = ANGLE_FRAC_BITS_DEF;
  localparam int NIT = ITERATIONS_DEF;
  localparam longint CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              ok;
  } dist_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_OWN_LNG;
  logic [28:0] cfg_data = '0;

  haversine_distance dut (.*);

  // arctangent table, floor(atan(2^-i) * 2^30)
  localparam longint ATAN_TBL [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007,
    32'h00000003, 32'h00000001, 32'h00000000, 32'h00000000};

  // local copy of the registers
  logic [LNG_W-1:0]  ref_lng = '0;
  logic [LAT_W-1:0]  ref_lat = '0;
  logic [DIST_W-1:0] radius = RADIUS_RESET;

  dist_word_t pending_dist[$];
  int  errors = 0;
  longint cycles = 0;
  int  send_idle = 0;
  int  recv_stall = 0;

  initial forever #5 clk = ~clk;

  function automatic longint tbl(int i);
    return ATAN_TBL[i] >>> (30 - FB);
  endfunction

  // sine and cosine, angle in degrees * 2^21
  function automatic void rot_sin_cos(longint v, output longint s, output longint c);
    longint x, y, z, dx, dy;
    longint d90, d180, d360;
    bit neg;
    d90 = DEG90; d180 = DEG180; d360 = DEG360;
    neg = 0;
    if (v > d180) v -= d360;
    if (v > d180) v -= d360;
    if (v <= -d180) v += d360;
    if (v <= -d180) v += d360;
    if (v > d90) begin
      v = d180 - v; neg = 1;
    end else if (v < -d90) begin
      v = -d180 - v; neg = 1;
    end
    z = (v * longint'(RAD_PER_DEG_Q32)) >>> (53 - FB);
    x = longint'(GAIN_INV_Q30) >>> (30 - FB);
    y = 0;
    for (int i = 0; i < NIT; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= tbl(i);
      end else begin
        x += dx; y -= dy; z += tbl(i);
      end
    end
    s = y;
    c = neg ? -x : x;
  endfunction

  function automatic longint vec_atan(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < NIT; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += tbl(i);
      end else begin
        x -= dx; y += dy; z -= tbl(i);
      end
    end
    return z;
  endfunction

  function automatic longint int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0; b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic dist_word_t great_circle(logic [LNG_W-1:0] plng, logic [LAT_W-1:0] plat);
    dist_word_t w;
    longint lng1, lat1, lng2, lat2, s1, c1, s2, c2, sl, cl, sg, cg, a, ra, rb, z, d;
    longint one;
    one = longint'(1) << FB;
    lng1 = longint'($signed(ref_lng)); lat1 = longint'($signed(ref_lat));
    lng2 = longint'($signed(plng));    lat2 = longint'($signed(plat));
    w = '0;
    if (lng1 == 0 || lat1 == 0 || lng2 == 0 || lat2 == 0) return w;
    rot_sin_cos(lat1 * 2, s1, c1);
    rot_sin_cos(lat2 * 2, s2, c2);
    rot_sin_cos(lat1 - lat2, sl, cl);
    rot_sin_cos(lng1 - lng2, sg, cg);
    a = ((sl * sl) >>> FB) + ((((c1 * c2) >>> FB) * ((sg * sg) >>> FB)) >>> FB);
    if (a < 0) a = 0;
    if (a > one) a = one;
    ra = int_root(longint'(a) << FB);
    rb = int_root(longint'(one - a) << FB);
    z = vec_atan(rb, ra);
    if (z < 0) z = 0;
    d = (longint'(radius) * z * 2) >>> FB;
    if (d > 4194303) d = 4194303;
    w.distance = d[DIST_W-1:0];
    w.ok = 1'b1;
    return w;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL haversine_distance");
      $finish;
    end
  end

  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_stall);

  // result checker
  always @(posedge clk) begin
    dist_word_t exp_w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_dist.size() == 0) begin
        $display("%0t unexpected word %h", $realtime, out_tdata);
        errors++;
      end else begin
        exp_w = pending_dist.pop_front();
        if (out_tdata[21:0] !== exp_w.distance || out_tdata[22] !== exp_w.ok ||
            out_tdata[23] !== 1'b0) begin
          $display("%0t mismatch: expected dist %0d valid %0d, got dist %0d valid %0d",
                   $realtime, exp_w.distance, exp_w.ok, out_tdata[21:0], out_tdata[22]);
          errors++;
        end
      end
    end
  end

  task automatic send_point(logic [LNG_W-1:0] plng, logic [LAT_W-1:0] plat);
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, plat, plng};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_dist.push_back(great_circle(plng, plat));
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // idle the input, let everything drain, then keep the input idle so late or stray words reach the checker
  task automatic drain_all();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_dist.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [28:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_OWN_LNG: ref_lng = val[LNG_W-1:0];
      REG_OWN_LAT: ref_lat = val[LAT_W-1:0];
      REG_RADIUS:  radius  = val[DIST_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_origin(logic [28:0] lng, logic [28:0] lat, logic [28:0] rad);
    write_reg(REG_OWN_LNG, lng);
    write_reg(REG_OWN_LAT, lat);
    write_reg(REG_RADIUS, rad);
  endtask

  function automatic logic [LNG_W-1:0] rand_lng();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 15) return LNG_W'($urandom());
    return LNG_W'($signed($urandom_range(377487360)) - 188743680);
  endfunction

  function automatic logic [LAT_W-1:0] rand_lat();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 15) return LAT_W'($urandom());
    return LAT_W'($signed($urandom_range(188743680)) - 94371840);
  endfunction

  task automatic test_reset_origin();
    // reference at zero after reset, every word is flagged invalid
    send_point(29'd1 << 20, 28'd1 << 20);
    send_point(29'h1FFFFFFF, 28'h0FFFFFF);
    drain_all();
  endtask

  task automatic test_directed();
    set_origin(29'(-128974234), 29'(47775989), 29'd1013504);
    send_point(29'(-128974234), 28'(47775989));   // same point
    send_point(29'd188743680, 28'd94371840);
    send_point(29'(-188743680), 28'(-94371840));
    send_point(29'd188743680, 28'(-94371840));
    send_point(29'(51 << 20), 28'(-47775989));    // mirrored latitude
    send_point(29'd0, 28'd1000);
    send_point(29'd1000, 28'd0);
    send_point(29'h0FFFFFFF, 28'h7FFFFFF);        // most positive patterns
    send_point(29'h10000000, 28'h8000000);        // most negative patterns
    send_point(29'd1, 28'd1);
    send_point(29'h1FFFFFFF, 28'hFFFFFFF);
    send_point(29'h15555555, 28'hAAAAAAA);
    send_point(29'h0AAAAAAA, 28'h5555555);
    drain_all();
    // ignored index must leave the radius alone
    write_reg(cfg_reg_t'(2'd3), 29'h1FFFFFFF);
    send_point(29'd200 << 20, 28'd30 << 20);
    drain_all();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_point(rand_lng(), rand_lat());
    drain_all();
  endtask

  task automatic test_extreme_configs();
    set_origin(29'd188743680, 29'd94371840, 29'd4194303);
    test_random(60);
    set_origin(29'(-188743680), 29'(-94371840), 29'd0);
    test_random(40);
    set_origin(29'h10000000, 29'h8000000, 29'd1);
    test_random(40);
    set_origin(29'h1FFFFFFF, 29'h0FFFFFFF, 29'h1FFFFFFF);
    test_random(40);
  endtask

  task automatic test_idle_phases();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1 || ph == 3) ? ((ph == 1) ? 66 : 33) : 0;
      recv_stall = (ph == 2 || ph == 3) ? ((ph == 2) ? 66 : 33) : 0;
      set_origin(29'($signed($urandom_range(377487360)) - 188743680),
                 29'($signed($urandom_range(188743680)) - 94371840),
                 29'($urandom_range(4194303)));
      test_random(120);
    end
    send_idle = 0;
    recv_stall = 0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_origin();
    test_directed();
    test_idle_phases();
    test_extreme_configs();
    drain_all();
    if (errors == 0 && pending_dist.size() == 0) begin
      $display("PASS haversine_distance");
    end else begin
      $display("FAIL haversine_distance");
    end
    $finish;
  end
endmodule

// File: sim.f
hdl/hav_pkg.sv
hdl/hav_rot_cell.sv
hdl/hav_vec_cell.sv
hdl/hav_sqrt_cell.sv
hdl/haversine_distance.sv
tb/tb_haversine_distance.sv
